[src/ccsr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccsr_pkg: shared types and constants of the claim/commit slot ring
// Command and result beat layouts, command kinds, register indexes and the
// default sizing of the ring.
// ----------------------------------------------------------------------------
package ccsr_pkg;

    // Field widths of the command and result beats
    localparam int KIND_W  = 2;
    localparam int SLOT_W  = 10;
    localparam int DATA_W  = 32;
    localparam int BATCH_W = 5;
    localparam int OCC_W   = 11;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int LOG2_W     = 4;
    localparam int STEP_W     = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_RING_LOG2  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOK_AHEAD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAIM_MODE = 2'd2;

    localparam logic [LOG2_W-1:0] RING_LOG2_RST  = 4'd10;
    localparam logic [STEP_W-1:0] LOOK_AHEAD_RST = 11'd32;

    // Claim modes
    localparam logic MODE_LOOK_AHEAD = 1'b0;
    localparam logic MODE_POSITION   = 1'b1;

    // Command kinds
    localparam logic [KIND_W-1:0] KIND_CLAIM  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COMMIT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    // Default sizing
    localparam int MAX_SLOTS_DEF    = 1024;
    localparam int PAYLOAD_BITS_DEF = 32;
    localparam int MAX_BATCH_DEF    = 16;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SLOT_W-1:0]  slot;
        logic [DATA_W-1:0]  payload;
        logic [BATCH_W-1:0] batch_count;
    } t_cmd;

    typedef struct packed {
        logic               ok;
        logic [SLOT_W-1:0]  slot_index;
        logic [DATA_W-1:0]  message_data;
        logic               last;
        logic [OCC_W-1:0]   occupancy;
    } t_res;

endpackage
`default_nettype wire

[src/claim_commit_slot_ring.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// claim_commit_slot_ring: bounded ring of slots with claim, commit and read
// Sequencer around one shared 64-bit add/subtract/compare unit and one slot
// memory holding a busy flag and the payload of every slot.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_cmd with start high; the beat is taken at an edge
//   where busy is low. An unused kind is taken and produces nothing.
//   Result channel: o_res_valid strobes each result for one cycle. There is no
//   back-pressure; the receiver must take every beat as it comes.
//   Config channel: i_cfg_valid/o_cfg_ready, index and data; o_cfg_ready stays
//   high, and writes are meant for times when no command is in flight.
// Sequencing, set by the sequencer stepping the shared 64-bit unit and the
// slot memory with its registered read: a commit writes its slot; a claim
//   compares positions and, in look-ahead mode, may probe slot flags; a batch
//   read scans and frees busy slots up to its count, advances the consumer,
//   then reads back and shows its results one at a time. Every command works
//   out the occupancy before its result; an empty read gives one not-ok beat.
//   The next command can be taken on the cycle the last result is shown.
// Reset: positions and registers return to defaults, then a clearing pass
//   frees every one of the MAX_SLOTS slots; busy stays high during that pass.
// ----------------------------------------------------------------------------
module claim_commit_slot_ring #(
    parameter int MAX_SLOTS    = ccsr_pkg::MAX_SLOTS_DEF,
    parameter int PAYLOAD_BITS = ccsr_pkg::PAYLOAD_BITS_DEF,
    parameter int MAX_BATCH    = ccsr_pkg::MAX_BATCH_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  start,
    output logic                                 busy,
    input  ccsr_pkg::t_cmd                       i_cmd,
    output logic                                 o_res_valid,
    output ccsr_pkg::t_res                       o_res,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [ccsr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [ccsr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int IDX_W   = $clog2(MAX_SLOTS);
    localparam int CAP_W   = IDX_W + 1;
    localparam int STORE_W = (PAYLOAD_BITS < ccsr_pkg::DATA_W) ? PAYLOAD_BITS
                                                               : ccsr_pkg::DATA_W;
    localparam int CNT_W   = $clog2(MAX_BATCH + 1);
    localparam int RAW_W   = 17;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_LA_CMP,
        S_LA_PROBE,
        S_LA_RD,
        S_LA_CK1,
        S_LA_CK2,
        S_PC_WRAP,
        S_PC_CMP1,
        S_PC_CMP2,
        S_GRANT,
        S_COMMIT,
        S_SCAN_RD,
        S_SCAN_CK,
        S_ADV,
        S_OCC,
        S_EMIT_RD,
        S_EMIT,
        S_OUT_ONE
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [ccsr_pkg::LOG2_W-1:0] r_ring_log2;
    logic [ccsr_pkg::STEP_W-1:0] r_step;
    logic                        r_mode;

    // Ring positions
    logic [63:0] r_prod;
    logic [63:0] r_cons;
    logic [63:0] r_cached;
    logic [63:0] r_tmp;

    // Item context
    ccsr_pkg::t_cmd              r_cmd;
    logic [CNT_W-1:0]            r_cnt;
    logic [CNT_W-1:0]            r_n;
    logic [CNT_W-1:0]            r_left;
    logic [IDX_W-1:0]            r_scan;
    logic [IDX_W-1:0]            r_start;
    logic [IDX_W-1:0]            r_clr;
    logic                        r_ok;
    logic [IDX_W-1:0]            r_slot;
    logic [ccsr_pkg::OCC_W-1:0]  r_occ;

    // Slot memory: busy flag on top of the payload
    logic [STORE_W:0]            r_mem [MAX_SLOTS];
    logic [STORE_W:0]            r_rd;

    logic                        w_mem_we;
    logic [IDX_W-1:0]            w_mem_waddr;
    logic [STORE_W:0]            w_mem_wdata;
    logic [IDX_W-1:0]            w_mem_raddr;

    // Ring geometry
    logic [ccsr_pkg::LOG2_W-1:0] w_lg;
    logic [RAW_W-1:0]            w_cap_raw;
    logic [CAP_W-1:0]            w_cap;
    logic [IDX_W-1:0]            w_mask;
    logic [IDX_W-1:0]            w_prod_idx;
    logic [IDX_W-1:0]            w_scan_idx;
    logic [IDX_W-1:0]            w_commit_idx;

    // Shared 64-bit unit
    logic [63:0]                 w_alu_a;
    logic [63:0]                 w_alu_b;
    logic                        w_alu_sub;
    logic                        w_alu_sgn;
    logic [64:0]                 w_alu_res;
    logic                        w_alu_neg;
    logic                        w_alu_le;

    logic                        w_rd_busy;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Derive capacity and index mask from the ring size register
    always_comb begin
        w_lg      = (r_ring_log2 == '0) ? ccsr_pkg::LOG2_W'(1) : r_ring_log2;
        w_cap_raw = RAW_W'(1) << w_lg;
        w_cap     = (int'(w_cap_raw) > MAX_SLOTS) ? CAP_W'(MAX_SLOTS) : CAP_W'(w_cap_raw);
        w_mask    = IDX_W'(w_cap - CAP_W'(1));
    end

    assign w_prod_idx   = r_prod[IDX_W-1:0] & w_mask;
    assign w_scan_idx   = r_scan & w_mask;
    assign w_commit_idx = IDX_W'(r_cmd.slot) & w_mask;
    assign w_rd_busy    = r_rd[STORE_W];

    // Select operands of the shared unit per sequencer step
    always_comb begin
        w_alu_a   = r_prod;
        w_alu_b   = 64'd1;
        w_alu_sub = 1'b0;
        w_alu_sgn = 1'b0;
        case (r_state)
            S_LA_CMP: begin
                w_alu_a   = r_prod;
                w_alu_b   = r_cached;
                w_alu_sub = 1'b1;
            end
            S_LA_PROBE: begin
                w_alu_a = r_cached;
                w_alu_b = 64'(r_step);
            end
            S_PC_WRAP: begin
                w_alu_a   = r_prod;
                w_alu_b   = 64'(w_cap);
                w_alu_sub = 1'b1;
            end
            S_PC_CMP1: begin
                w_alu_a   = r_cached;
                w_alu_b   = r_tmp;
                w_alu_sub = 1'b1;
                w_alu_sgn = 1'b1;
            end
            S_PC_CMP2: begin
                w_alu_a   = r_cons;
                w_alu_b   = r_tmp;
                w_alu_sub = 1'b1;
                w_alu_sgn = 1'b1;
            end
            S_ADV: begin
                w_alu_a = r_cons;
                w_alu_b = 64'(r_n);
            end
            S_OCC: begin
                w_alu_a   = r_prod;
                w_alu_b   = r_cons;
                w_alu_sub = 1'b1;
                w_alu_sgn = 1'b1;
            end
            default: begin
                w_alu_a = r_prod;
                w_alu_b = 64'd1;
            end
        endcase
    end

    // Add or subtract on 65 bits; the top bit gives the compare result
    always_comb begin
        if (w_alu_sub) begin
            w_alu_res = {w_alu_sgn & w_alu_a[63], w_alu_a} - {w_alu_sgn & w_alu_b[63], w_alu_b};
        end else begin
            w_alu_res = {w_alu_sgn & w_alu_a[63], w_alu_a} + {w_alu_sgn & w_alu_b[63], w_alu_b};
        end
        w_alu_neg = w_alu_res[64];
        w_alu_le  = w_alu_res[64] | (w_alu_res == '0);
    end

    // Drive slot memory ports per sequencer step
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_clr;
        w_mem_wdata = '0;
        w_mem_raddr = '0;
        case (r_state)
            S_CLEAR: begin
                w_mem_we = 1'b1;
            end
            S_LA_RD: begin
                w_mem_raddr = r_tmp[IDX_W-1:0] & w_mask;
            end
            S_LA_CK1: begin
                w_mem_raddr = w_prod_idx;
            end
            S_COMMIT: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = w_commit_idx;
                w_mem_wdata = {1'b1, STORE_W'(r_cmd.payload)};
            end
            S_SCAN_RD: begin
                w_mem_raddr = w_scan_idx;
            end
            S_SCAN_CK: begin
                w_mem_we    = w_rd_busy;
                w_mem_waddr = w_scan_idx;
                w_mem_wdata = {1'b0, r_rd[STORE_W-1:0]};
            end
            S_EMIT_RD: begin
                w_mem_raddr = w_scan_idx;
            end
            default: begin
                w_mem_we = 1'b0;
            end
        endcase
    end

    // Slot memory with registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        r_rd <= r_mem[w_mem_raddr];
    end

    // Sequencer, ring state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_ring_log2 <= ccsr_pkg::RING_LOG2_RST;
            r_step      <= ccsr_pkg::LOOK_AHEAD_RST;
            r_mode      <= ccsr_pkg::MODE_LOOK_AHEAD;
            r_prod      <= '0;
            r_cons      <= '0;
            r_cached    <= '0;
            o_res_valid <= 1'b0;
        end else begin
            o_res_valid <= 1'b0;

            // Take register writes
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ccsr_pkg::CFG_RING_LOG2:  r_ring_log2 <= i_cfg_data[ccsr_pkg::LOG2_W-1:0];
                    ccsr_pkg::CFG_LOOK_AHEAD: r_step      <= i_cfg_data[ccsr_pkg::STEP_W-1:0];
                    ccsr_pkg::CFG_CLAIM_MODE: r_mode      <= i_cfg_data[0];
                    default: ;
                endcase
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + IDX_W'(1);
                    if (r_clr == IDX_W'(MAX_SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_cmd   <= i_cmd;
                        r_n     <= '0;
                        r_scan  <= r_cons[IDX_W-1:0];
                        r_start <= r_cons[IDX_W-1:0];
                        if (int'(i_cmd.batch_count) > MAX_BATCH) begin
                            r_cnt <= CNT_W'(MAX_BATCH);
                        end else begin
                            r_cnt <= CNT_W'(i_cmd.batch_count);
                        end
                        case (i_cmd.kind)
                            ccsr_pkg::KIND_CLAIM: begin
                                r_state <= (r_mode == ccsr_pkg::MODE_POSITION) ? S_PC_WRAP
                                                                               : S_LA_CMP;
                            end
                            ccsr_pkg::KIND_COMMIT: r_state <= S_COMMIT;
                            ccsr_pkg::KIND_READ:   r_state <= S_SCAN_RD;
                            default:               r_state <= S_IDLE;
                        endcase
                    end
                end
                // Look-ahead claim: grant at once while behind the cached position
                S_LA_CMP: begin
                    r_state <= w_alu_neg ? S_GRANT : S_LA_PROBE;
                end
                S_LA_PROBE: begin
                    r_tmp   <= w_alu_res[63:0];
                    r_state <= S_LA_RD;
                end
                S_LA_RD: begin
                    r_state <= S_LA_CK1;
                end
                S_LA_CK1: begin
                    if (!w_rd_busy) begin
                        r_cached <= r_tmp;
                        r_state  <= S_GRANT;
                    end else begin
                        r_state <= S_LA_CK2;
                    end
                end
                S_LA_CK2: begin
                    if (!w_rd_busy) begin
                        r_state <= S_GRANT;
                    end else begin
                        r_ok    <= 1'b0;
                        r_slot  <= '0;
                        r_state <= S_OCC;
                    end
                end
                // Position claim: compare against producer minus capacity
                S_PC_WRAP: begin
                    r_tmp   <= w_alu_res[63:0];
                    r_state <= S_PC_CMP1;
                end
                S_PC_CMP1: begin
                    r_state <= w_alu_le ? S_PC_CMP2 : S_GRANT;
                end
                S_PC_CMP2: begin
                    if (w_alu_le) begin
                        r_ok    <= 1'b0;
                        r_slot  <= '0;
                        r_state <= S_OCC;
                    end else begin
                        r_cached <= r_cons;
                        r_state  <= S_GRANT;
                    end
                end
                S_GRANT: begin
                    r_ok    <= 1'b1;
                    r_slot  <= w_prod_idx;
                    r_prod  <= w_alu_res[63:0];
                    r_state <= S_OCC;
                end
                S_COMMIT: begin
                    r_ok    <= 1'b1;
                    r_slot  <= w_commit_idx;
                    r_state <= S_OCC;
                end
                // Scan and free busy slots in order, up to the batch count
                S_SCAN_RD: begin
                    r_state <= (r_n == r_cnt) ? S_ADV : S_SCAN_CK;
                end
                S_SCAN_CK: begin
                    if (w_rd_busy) begin
                        r_n     <= r_n + CNT_W'(1);
                        r_scan  <= r_scan + IDX_W'(1);
                        r_state <= S_SCAN_RD;
                    end else begin
                        r_state <= S_ADV;
                    end
                end
                S_ADV: begin
                    r_cons  <= w_alu_res[63:0];
                    r_left  <= r_n;
                    r_scan  <= r_start;
                    r_ok    <= 1'b0;
                    r_slot  <= '0;
                    r_state <= S_OCC;
                end
                // Occupancy after the step: zero when consumer leads, else the difference, saturated
                S_OCC: begin
                    if (w_alu_neg) begin
                        r_occ <= '0;
                    end else if (|w_alu_res[63:ccsr_pkg::OCC_W]) begin
                        r_occ <= '1;
                    end else begin
                        r_occ <= w_alu_res[ccsr_pkg::OCC_W-1:0];
                    end
                    if (r_cmd.kind == ccsr_pkg::KIND_READ && r_n != '0) begin
                        r_state <= S_EMIT_RD;
                    end else begin
                        r_state <= S_OUT_ONE;
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    o_res_valid            <= 1'b1;
                    o_res.ok               <= 1'b1;
                    o_res.slot_index       <= ccsr_pkg::SLOT_W'(w_scan_idx);
                    o_res.message_data     <= ccsr_pkg::DATA_W'(r_rd[STORE_W-1:0]);
                    o_res.last             <= (r_left == CNT_W'(1));
                    o_res.occupancy        <= r_occ;
                    r_left                 <= r_left - CNT_W'(1);
                    r_scan                 <= r_scan + IDX_W'(1);
                    r_state                <= (r_left == CNT_W'(1)) ? S_IDLE : S_EMIT_RD;
                end
                S_OUT_ONE: begin
                    o_res_valid            <= 1'b1;
                    o_res.ok               <= r_ok;
                    o_res.slot_index       <= ccsr_pkg::SLOT_W'(r_slot);
                    o_res.message_data     <= '0;
                    o_res.last             <= 1'b1;
                    o_res.occupancy        <= r_occ;
                    r_state                <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[src/ccsr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccsr_checker: port-level checks of the claim/commit slot ring
// Watches the command, result and config ports and flags broken sequencing.
// ----------------------------------------------------------------------------
module ccsr_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  start,
    input wire                  busy,
    input ccsr_pkg::t_cmd       i_cmd,
    input wire                  o_res_valid,
    input ccsr_pkg::t_res       o_res,
    input wire                  o_cfg_ready
);

    // A taken command with a real kind keeps the block busy next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.kind == ccsr_pkg::KIND_CLAIM ||
                            i_cmd.kind == ccsr_pkg::KIND_COMMIT ||
                            i_cmd.kind == ccsr_pkg::KIND_READ)) |=> busy)
        else $error("command taken but block not busy");

    // More results of a batch still owed: hold off new commands
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.last) |-> busy)
        else $error("block idle before final result beat");

    // A refused or empty result is a lone beat with zero slot and data
    a_fail_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.ok) |->
            (o_res.last && o_res.slot_index == '0 && o_res.message_data == '0))
        else $error("not-ok result beat malformed");

    // Occupancy holds between the beats of one batch
    a_occ_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.last) |=> ##1
            (!o_res_valid || o_res.occupancy == $past(o_res.occupancy, 2)))
        else $error("occupancy changed within one batch");

    // Config port never blocks
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

endmodule

bind claim_commit_slot_ring ccsr_checker u_ccsr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_cmd       (i_cmd),
    .o_res_valid (o_res_valid),
    .o_res       (o_res),
    .o_cfg_ready (o_cfg_ready)
);
`default_nettype wire

[tb/tb_claim_commit_slot_ring.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_claim_commit_slot_ring: self-checking bench for the claim/commit ring
// Walks a short table of claims, commits and reads, then random traffic built
// mostly of claim-then-commit pairs with reads mixed in, under several ring
// sizes, look-ahead steps and claim modes. A burst of claims at the end runs
// an oversized ring with the widest step. Every result beat is checked field by
// field against the table's beat or a model of positions, slot flags and contents.
// ----------------------------------------------------------------------------
module tb_claim_commit_slot_ring;

    localparam logic [ccsr_pkg::KIND_W-1:0] KIND_IDLE = 2'd3;  // taken, produces nothing
    localparam int RING_SLOTS    = ccsr_pkg::MAX_SLOTS_DEF;
    localparam int SETTLE_CYCLES = 100;  // longer than a full 16-slot read
    localparam int BURST_CLAIMS  = 16;
    localparam int RANDOM_ITEMS  = 50;

    typedef struct {
        ccsr_pkg::t_cmd cmd;
        bit             typed;
        ccsr_pkg::t_res want;
    } t_plan_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    ccsr_pkg::t_cmd                  i_cmd;
    logic                            o_res_valid;
    ccsr_pkg::t_res                  o_res;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [ccsr_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [ccsr_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // Model state of the ring
    logic [63:0]                 prod_pos;
    logic [63:0]                 cons_pos;
    logic [63:0]                 cache_pos;
    bit                          slot_full [RING_SLOTS];
    logic [ccsr_pkg::DATA_W-1:0] slot_data [RING_SLOTS];
    logic [ccsr_pkg::LOG2_W-1:0] cfg_log2;
    logic [ccsr_pkg::STEP_W-1:0] cfg_step;
    logic                        cfg_mode;

    ccsr_pkg::t_res              results_due [$];
    logic [ccsr_pkg::SLOT_W-1:0] claimed_slots [$];
    bit                          claim_ok;
    logic [ccsr_pkg::SLOT_W-1:0] claim_slot;
    int                          fail_cnt;
    t_plan_row                   plan [$];

    claim_commit_slot_ring dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Fill level is producer minus consumer, zero when the consumer leads, saturated at 2047
    function automatic logic [ccsr_pkg::OCC_W-1:0] fill_level();
        logic [63:0] span;
        if ($signed(cons_pos) > $signed(prod_pos)) return '0;
        span = prod_pos - cons_pos;
        return (span > 64'd2047) ? 11'd2047 : span[ccsr_pkg::OCC_W-1:0];
    endfunction

    // Advance the ring model by one accepted command and queue its results
    function automatic void compute_ring_results(input ccsr_pkg::t_cmd c, input bit typed,
                                                 input ccsr_pkg::t_res want);
        ccsr_pkg::t_res              outs [$];
        ccsr_pkg::t_res              r;
        logic [63:0]                 cap;
        logic [63:0]                 mask;
        logic [63:0]                 probe;
        logic [63:0]                 wrap;
        logic [ccsr_pkg::SLOT_W-1:0] idx;
        logic [ccsr_pkg::OCC_W-1:0]  occ;
        int                          cnt;
        bit                          granted;
        cap  = 64'd1 << ((cfg_log2 == 0) ? 1 : cfg_log2);
        if (cap > 64'(RING_SLOTS)) cap = 64'(RING_SLOTS);
        mask = cap - 64'd1;
        r    = '0;
        case (c.kind)
            ccsr_pkg::KIND_CLAIM: begin
                granted = 1'b1;
                if (cfg_mode == ccsr_pkg::MODE_POSITION) begin
                    wrap = prod_pos - cap;
                    if ($signed(cache_pos) <= $signed(wrap)) begin
                        if ($signed(cons_pos) <= $signed(wrap)) granted = 1'b0;
                        else cache_pos = cons_pos;
                    end
                end else if (prod_pos >= cache_pos) begin
                    probe = cache_pos + 64'(cfg_step);
                    if (!slot_full[probe & mask]) cache_pos = probe;
                    else granted = !slot_full[prod_pos & mask];
                end
                r.last = 1'b1;
                if (granted) begin
                    r.ok         = 1'b1;
                    r.slot_index = ccsr_pkg::SLOT_W'(prod_pos & mask);
                    prod_pos     = prod_pos + 64'd1;
                end
                claim_ok   = granted;
                claim_slot = r.slot_index;
                outs.push_back(r);
            end
            ccsr_pkg::KIND_COMMIT: begin
                idx            = c.slot & ccsr_pkg::SLOT_W'(mask);
                slot_data[idx] = c.payload;
                slot_full[idx] = 1'b1;
                r.ok           = 1'b1;
                r.slot_index   = idx;
                r.last         = 1'b1;
                outs.push_back(r);
            end
            ccsr_pkg::KIND_READ: begin
                cnt = (int'(c.batch_count) > ccsr_pkg::MAX_BATCH_DEF) ? ccsr_pkg::MAX_BATCH_DEF
                                                                      : int'(c.batch_count);
                while (outs.size() < cnt && slot_full[cons_pos & mask]) begin
                    idx            = ccsr_pkg::SLOT_W'(cons_pos & mask);
                    r.ok           = 1'b1;
                    r.slot_index   = idx;
                    r.message_data = slot_data[idx];
                    outs.push_back(r);
                    slot_full[idx] = 1'b0;
                    cons_pos       = cons_pos + 64'd1;
                end
                if (outs.size() == 0) begin
                    r      = '0;
                    r.last = 1'b1;
                end else begin
                    r      = outs.pop_back();
                    r.last = 1'b1;
                end
                outs.push_back(r);
            end
            default: ;
        endcase
        occ = fill_level();
        foreach (outs[k]) begin
            r           = outs[k];
            r.occupancy = occ;
            results_due.push_back(typed ? want : r);
        end
    endfunction

    // Hand one command beat over and update the model at the accepting edge
    task automatic issue(input ccsr_pkg::t_cmd c, input bit typed, input ccsr_pkg::t_res want);
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        compute_ring_results(c, typed, want);
    endtask

    task automatic hold_off(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    function automatic int idle_gap(input int pct);
        int n;
        n = 0;
        while (n < 40 && $urandom_range(99) < pct) n++;
        return n;
    endfunction

    // Drop start and wait for every queued result beat
    task automatic wait_drained();
        hold_off(1);
        while (results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ccsr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ccsr_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            ccsr_pkg::CFG_RING_LOG2:  cfg_log2 = val[ccsr_pkg::LOG2_W-1:0];
            ccsr_pkg::CFG_LOOK_AHEAD: cfg_step = val[ccsr_pkg::STEP_W-1:0];
            ccsr_pkg::CFG_CLAIM_MODE: cfg_mode = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Reconfigure only once the ring has gone quiet
    task automatic set_ring(input logic [ccsr_pkg::CFG_DATA_W-1:0] log2_val,
                            input logic [ccsr_pkg::CFG_DATA_W-1:0] step_val,
                            input logic mode);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(ccsr_pkg::CFG_RING_LOG2, log2_val);
        write_reg(ccsr_pkg::CFG_LOOK_AHEAD, step_val);
        write_reg(ccsr_pkg::CFG_CLAIM_MODE, {{(ccsr_pkg::CFG_DATA_W-1){1'b0}}, mode});
        claimed_slots.delete();
    endtask

    // Mostly claim-then-commit pairs and reads, with some malformed commands
    task automatic random_phase(input int n_items, input int idle_pct);
        ccsr_pkg::t_cmd c;
        int             done;
        int             pick;
        done = 0;
        while (done < n_items) begin
            if (done == n_items / 2) wait_drained();
            c.slot        = ccsr_pkg::SLOT_W'($urandom);
            c.payload     = $urandom;
            c.batch_count = ccsr_pkg::BATCH_W'($urandom);
            pick          = $urandom_range(99);
            if (pick < 45) begin
                c.kind = ccsr_pkg::KIND_CLAIM;
            end else if (pick < 75) begin
                c.kind = ccsr_pkg::KIND_COMMIT;
                if (claimed_slots.size() != 0) c.slot = claimed_slots.pop_front();
            end else if (pick < 88) begin
                c.kind        = ccsr_pkg::KIND_READ;
                c.batch_count = ccsr_pkg::BATCH_W'($urandom_range(1, ccsr_pkg::MAX_BATCH_DEF));
            end else if (pick < 94) begin
                c.kind = ccsr_pkg::KIND_COMMIT;
            end else if (pick < 97) begin
                c.kind        = ccsr_pkg::KIND_READ;
                c.batch_count = $urandom_range(1) ? 5'd0
                                                  : ccsr_pkg::BATCH_W'($urandom_range(17, 31));
            end else begin
                c.kind = KIND_IDLE;
            end
            hold_off(idle_gap(idle_pct));
            issue(c, 1'b0, '0);
            if (c.kind != KIND_IDLE) done++;
            if (c.kind == ccsr_pkg::KIND_CLAIM && claim_ok) claimed_slots.push_back(claim_slot);
        end
    endtask

    function automatic ccsr_pkg::t_cmd cmd_of(input logic [ccsr_pkg::KIND_W-1:0] k,
                                              input logic [ccsr_pkg::SLOT_W-1:0] s,
                                              input logic [ccsr_pkg::DATA_W-1:0] p,
                                              input logic [ccsr_pkg::BATCH_W-1:0] n);
        ccsr_pkg::t_cmd c;
        c.kind        = k;
        c.slot        = s;
        c.payload     = p;
        c.batch_count = n;
        return c;
    endfunction

    function automatic ccsr_pkg::t_res res_of(input logic ok,
                                              input logic [ccsr_pkg::SLOT_W-1:0] s,
                                              input logic [ccsr_pkg::OCC_W-1:0] occ);
        ccsr_pkg::t_res r;
        r              = '0;
        r.ok           = ok;
        r.slot_index   = s;
        r.last         = 1'b1;
        r.occupancy    = occ;
        return r;
    endfunction

    // Check each result beat against the oldest expectation
    always @(posedge i_clk) begin
        ccsr_pkg::t_res want;
        if (i_rst_n && o_res_valid) begin
            if (results_due.size() == 0) begin
                fail_cnt++;
                $display("%0t: expected no result, actual ok/slot/data/last/occ %0d/%0d/%h/%0d/%0d",
                         $time, o_res.ok, o_res.slot_index, o_res.message_data,
                         o_res.last, o_res.occupancy);
            end else begin
                want = results_due.pop_front();
                if (want.ok !== o_res.ok || want.slot_index !== o_res.slot_index ||
                    want.message_data !== o_res.message_data ||
                    want.last !== o_res.last || want.occupancy !== o_res.occupancy) begin
                    fail_cnt++;
                    $display(
                        "%0t: expected %0d/%0d/%h/%0d/%0d, actual %0d/%0d/%h/%0d/%0d",
                        $time, want.ok, want.slot_index, want.message_data,
                        want.last, want.occupancy, o_res.ok, o_res.slot_index,
                        o_res.message_data, o_res.last, o_res.occupancy);
                end
            end
        end
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        logic [ccsr_pkg::SLOT_W-1:0] slot_pick;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        fail_cnt    = 0;
        prod_pos    = '0;
        cons_pos    = '0;
        cache_pos   = '0;
        cfg_log2    = ccsr_pkg::RING_LOG2_RST;
        cfg_step    = ccsr_pkg::LOOK_AHEAD_RST;
        cfg_mode    = ccsr_pkg::MODE_LOOK_AHEAD;
        foreach (slot_full[k]) slot_full[k] = 1'b0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table at the reset settings
        plan.push_back('{cmd_of(ccsr_pkg::KIND_READ, 10'd0, 32'd0, 5'd1), 1'b1,
                         res_of(1'b0, 10'd0, 11'd0)});
        plan.push_back('{cmd_of(ccsr_pkg::KIND_CLAIM, 10'h3FF, 32'hFFFF_FFFF, 5'd31), 1'b1,
                         res_of(1'b1, 10'd0, 11'd1)});
        plan.push_back('{cmd_of(ccsr_pkg::KIND_COMMIT, 10'd0, 32'hFFFF_FFFF, 5'd0), 1'b1,
                         res_of(1'b1, 10'd0, 11'd1)});
        plan.push_back('{cmd_of(ccsr_pkg::KIND_CLAIM, 10'd0, 32'd0, 5'd0), 1'b1,
                         res_of(1'b1, 10'd1, 11'd2)});
        plan.push_back('{cmd_of(ccsr_pkg::KIND_COMMIT, 10'd1, 32'd0, 5'd31), 1'b1,
                         res_of(1'b1, 10'd1, 11'd2)});
        plan.push_back('{cmd_of(ccsr_pkg::KIND_COMMIT, 10'h3FF, 32'hA5A5_5A5A, 5'd0), 1'b1,
                         res_of(1'b1, 10'h3FF, 11'd2)});
        plan.push_back('{cmd_of(ccsr_pkg::KIND_READ, 10'd0, 32'd0, 5'd16), 1'b0, '0});
        plan.push_back('{cmd_of(ccsr_pkg::KIND_READ, 10'h3FF, 32'hFFFF_FFFF, 5'd0), 1'b1,
                         res_of(1'b0, 10'd0, 11'd0)});
        plan.push_back('{cmd_of(KIND_IDLE, 10'h3FF, 32'hFFFF_FFFF, 5'd31), 1'b0, '0});
        plan.push_back('{cmd_of(ccsr_pkg::KIND_READ, 10'd0, 32'd0, 5'd31), 1'b1,
                         res_of(1'b0, 10'd0, 11'd0)});
        plan.push_back('{cmd_of(ccsr_pkg::KIND_CLAIM, 10'd0, 32'd0, 5'd0), 1'b1,
                         res_of(1'b1, 10'd2, 11'd1)});
        plan.push_back('{cmd_of(ccsr_pkg::KIND_COMMIT, 10'd2, 32'h1234_5678, 5'd0), 1'b0, '0});
        // commits to slots nobody claimed put the consumer ahead of the producer
        plan.push_back('{cmd_of(ccsr_pkg::KIND_COMMIT, 10'd3, 32'h0000_FFFF, 5'd0), 1'b0, '0});
        plan.push_back('{cmd_of(ccsr_pkg::KIND_COMMIT, 10'd4, 32'hFFFF_0000, 5'd0), 1'b0, '0});
        plan.push_back('{cmd_of(ccsr_pkg::KIND_READ, 10'd0, 32'd0, 5'd17), 1'b0, '0});
        plan.push_back('{cmd_of(ccsr_pkg::KIND_CLAIM, 10'd0, 32'd0, 5'd0), 1'b0, '0});
        plan.push_back('{cmd_of(ccsr_pkg::KIND_READ, 10'd0, 32'd0, 5'd5), 1'b0, '0});
        foreach (plan[i]) begin
            hold_off(idle_gap(24));
            issue(plan[i].cmd, plan[i].typed, plan[i].want);
        end

        // Random traffic: two slots with step zero, then the ring size of zero
        // in position mode, then a small ring with a wide step
        set_ring(11'd1, 11'd0, ccsr_pkg::MODE_LOOK_AHEAD);
        random_phase(RANDOM_ITEMS, 24);
        set_ring(11'd0, 11'd1, ccsr_pkg::MODE_POSITION);
        random_phase(RANDOM_ITEMS, 86);
        set_ring(11'd3, 11'd1024, ccsr_pkg::MODE_POSITION);
        random_phase(RANDOM_ITEMS, 0);

        // Burst of claims with an oversized ring and the widest step
        set_ring(11'd15, 11'd2047, ccsr_pkg::MODE_LOOK_AHEAD);
        repeat (BURST_CLAIMS) begin
            issue(cmd_of(ccsr_pkg::KIND_CLAIM, ccsr_pkg::SLOT_W'($urandom), $urandom,
                         ccsr_pkg::BATCH_W'($urandom)), 1'b0, '0);
            if (claim_ok) claimed_slots.push_back(claim_slot);
        end
        repeat (8) begin
            slot_pick = (claimed_slots.size() != 0) ? claimed_slots.pop_front()
                                                    : ccsr_pkg::SLOT_W'($urandom);
            issue(cmd_of(ccsr_pkg::KIND_COMMIT, slot_pick, $urandom, 5'd0), 1'b0, '0);
            issue(cmd_of(ccsr_pkg::KIND_READ, 10'd0, 32'd0, 5'd16), 1'b0, '0);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && results_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
